### rtl/core/rstc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rstc_pkg: shared types and constants
// store geometry, exp table, control and status bundles
// ----------------------------------------------------------------------------
package rstc_pkg;

  localparam int MAX_RATIO      = 32;
  localparam int MAX_HEAD       = 128;
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;

  localparam int SLOT_W  = $clog2(2 * MAX_RATIO);
  localparam int SUB_W   = $clog2(MAX_RATIO);
  localparam int LANE_W  = $clog2(2 * MAX_HEAD);
  localparam int ADDR_W  = SLOT_W + LANE_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int NUM_W   = 40;
  localparam int DEN_W   = 23;
  localparam int CNT_W   = 6;

  localparam logic [1:0] REG_WINDOW_RATIO = 2'd0;
  localparam logic [1:0] REG_HEAD_WIDTH   = 2'd1;
  localparam logic [1:0] REG_OVERLAP_MODE = 2'd2;

  typedef logic [EXP_SIZE-1:0][16:0] exp_tab_t;

  // shift-subtract quotient, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    longint      sum;
    longint      term;
    logic [63:0] e;
    logic [63:0] p;
    sum  = 64'sh1_0000_0000;
    term = 64'sh1_0000_0000;
    p    = 64'h1_0000_0000;
    for (int n = 1; n <= 40; n++) begin
      term = longint'(udiv64(64'(term >>> (EXP_TABLE_BITS - 4)), 64'(n)));
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    e = 64'(sum);
    for (int k = 0; k < EXP_SIZE; k++) begin
      t[k] = 17'((p + 64'd32768) >> 16);
      p    = (p * e) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef struct packed {
    logic [5:0] ratio;
    logic [7:0] head;
    logic       ovl;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_zero;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              sum_phase;
    logic              max_init;
    logic              sum_init;
    logic              div_start;
    logic              out_load;
    logic [6:0]        out_lane;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/rstc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rstc_ctrl: sequencer
// store clearing, token bookkeeping, pooling passes and output handoff
// ----------------------------------------------------------------------------
module rstc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rstc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  logic          last_element_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rstc_pkg::cmd_t cmd_o,
  input  rstc_pkg::sts_t sts_i
);
  import rstc_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MAX   = 4'd2;
  localparam logic [3:0] ST_MAXW  = 4'd3;
  localparam logic [3:0] ST_SUM   = 4'd4;
  localparam logic [3:0] ST_SUMW  = 4'd5;
  localparam logic [3:0] ST_DIVW  = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [8:0]        elem_q, elem_d;
  logic [SUB_W-1:0]  cursor_q, cursor_d;
  logic              bank_q, bank_d;
  logic              pbank_q, pbank_d;
  logic [6:0]        lane_q, lane_d;
  logic [6:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;

  logic [5:0]        ratio;
  logic [7:0]        head;
  logic [8:0]        tw;
  logic [SUB_W-1:0]  cur;
  logic              closing;
  logic              wr_ok;
  logic              emit;
  logic [8:0]        lane_full;
  logic              accept;
  logic [6:0]        npass;
  logic [SUB_W-1:0]  sub;
  logic              upper;
  logic [LANE_W-1:0] rlane;

  always_comb begin
    if (cfg_i.ratio == 6'd0) ratio = 6'd1;
    else if (cfg_i.ratio > 6'(MAX_RATIO)) ratio = 6'(MAX_RATIO);
    else ratio = cfg_i.ratio;
    if (cfg_i.head == 8'd0) head = 8'd1;
    else if (cfg_i.head > 8'(MAX_HEAD)) head = 8'(MAX_HEAD);
    else head = cfg_i.head;
  end

  assign tw        = cfg_i.ovl ? {head, 1'b0} : {1'b0, head};
  assign cur       = ({1'b0, cursor_q} < ratio) ? cursor_q : SUB_W'(ratio - 6'd1);
  assign closing   = ({1'b0, cur} == (ratio - 6'd1));
  assign wr_ok     = elem_q < tw;
  assign emit      = wr_ok && closing && (!cfg_i.ovl || elem_q >= {1'b0, head});
  assign lane_full = cfg_i.ovl ? elem_q - {1'b0, head} : elem_q;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign npass     = cfg_i.ovl ? {ratio, 1'b0} : {1'b0, ratio};
  assign sub       = cfg_i.ovl ? idx_q[SUB_W:1] : idx_q[SUB_W-1:0];
  assign upper     = cfg_i.ovl ? idx_q[0] : 1'b1;
  assign rlane     = (cfg_i.ovl && upper) ? {1'b0, lane_q} + head : {1'b0, lane_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    elem_d      = elem_q;
    cursor_d    = cursor_q;
    bank_d      = bank_q;
    pbank_d     = pbank_q;
    lane_d      = lane_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;

    cmd_o           = '0;
    cmd_o.wr_addr   = {bank_q, cur, elem_q[LANE_W-1:0]};
    cmd_o.rd_addr   = {(upper ? pbank_q : ~pbank_q), sub, rlane};
    cmd_o.out_lane  = lane_q;
    cmd_o.out_last  = (lane_q == 7'(head - 8'd1));
    cmd_o.sum_phase = (state_q == ST_SUM) || (state_q == ST_SUMW);

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_zero = 1'b1;
        cmd_o.wr_addr = clr_q;
        clr_d         = clr_q + 1'b1;
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.wr_en = wr_ok;
          if (wr_ok) elem_d = elem_q + 9'd1;
          if (emit) begin
            cmd_o.max_init = 1'b1;
            pbank_d        = bank_q;
            lane_d         = lane_full[6:0];
            idx_d          = '0;
            state_d        = ST_MAX;
          end
          if (last_element_i) begin
            elem_d = '0;
            if (closing) begin
              cursor_d = '0;
              if (cfg_i.ovl) bank_d = ~bank_q;
            end else begin
              cursor_d = cur + 1'b1;
            end
          end
        end
      end
      ST_MAX: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 7'd1;
        if (idx_q == npass - 7'd1) state_d = ST_MAXW;
      end
      ST_MAXW: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.sum_init = 1'b1;
          idx_d          = '0;
          state_d        = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 7'd1;
        if (idx_q == npass - 7'd1) state_d = ST_SUMW;
      end
      ST_SUMW: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (!sts_i.div_busy) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      elem_q      <= '0;
      cursor_q    <= '0;
      bank_q      <= 1'b0;
      pbank_q     <= 1'b0;
      lane_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      elem_q      <= elem_d;
      cursor_q    <= cursor_d;
      bank_q      <= bank_d;
      pbank_q     <= pbank_d;
      lane_q      <= lane_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rstc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rstc_dp: datapath
// slot store, max search, weighted sums, bit-serial divider, output register
// ----------------------------------------------------------------------------
module rstc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rstc_pkg::cmd_t      cmd_i,
  output rstc_pkg::sts_t      sts_o,
  input  logic signed [15:0]  kv_value_i,
  input  logic signed [15:0]  score_value_i,
  input  logic signed [15:0]  position_bias_i,
  output logic signed [15:0]  compressed_value_o,
  output logic [6:0]          lane_index_o,
  output logic                last_of_window_o
);
  import rstc_pkg::*;

  logic [31:0]             mem [DEPTH];
  logic [31:0]             rdata_q;
  logic [31:0]             wdata;
  logic signed [16:0]      score_sum;
  logic signed [15:0]      score_sat;
  logic signed [15:0]      rd_score;
  logic signed [15:0]      rd_val;
  logic                    v1_q;
  logic                    v2_q;
  logic signed [15:0]      max_q;
  logic signed [16:0]      diff;
  logic [16:0]             w;
  logic [16:0]             w_q;
  logic signed [15:0]      val_q;
  logic signed [33:0]      prod;
  logic signed [NUM_W-1:0] num_q;
  logic [DEN_W-1:0]        den_q;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W-1:0]        quo_q;
  logic [DEN_W-1:0]        rem_q;
  logic [DEN_W:0]          rem_sh;
  logic                    neg_q;
  logic                    div_act_q;
  logic [CNT_W-1:0]        div_cnt_q;
  logic signed [15:0]      sat_val;
  logic signed [15:0]      out_val_q;
  logic [6:0]              out_lane_q;
  logic                    out_last_q;

  assign score_sum = {score_value_i[15], score_value_i} + {position_bias_i[15], position_bias_i};

  always_comb begin
    if (score_sum[16] != score_sum[15]) begin
      score_sat = score_sum[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      score_sat = score_sum[15:0];
    end
  end

  assign wdata = cmd_i.wr_zero ? 32'd0 : {kv_value_i, score_sat};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[cmd_i.wr_addr] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[cmd_i.rd_addr];
  end

  assign rd_score = rdata_q[15:0];
  assign rd_val   = rdata_q[31:16];

  assign diff = {max_q[15], max_q} - {rd_score[15], rd_score};
  assign w    = (|diff[16:12]) ? 17'd0 : EXP_TAB[diff[11 -: EXP_TABLE_BITS]];
  assign prod = $signed({1'b0, w_q}) * val_q;

  assign mag    = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign rem_sh = {rem_q, quo_q[NUM_W-1]};

  always_comb begin
    if (!neg_q) begin
      sat_val = (|quo_q[NUM_W-1:15]) ? 16'sh7fff : quo_q[15:0];
    end else begin
      sat_val = (quo_q > NUM_W'(32768)) ? 16'sh8000 : 16'(16'd0 - quo_q[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      div_act_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q && cmd_i.sum_phase;
      if (cmd_i.div_start) begin
        div_act_q <= 1'b1;
        div_cnt_q <= CNT_W'(NUM_W);
      end else if (div_act_q) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == CNT_W'(1)) div_act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.max_init) begin
      max_q <= 16'sh8000;
    end else if (v1_q && !cmd_i.sum_phase && (rd_score > max_q)) begin
      max_q <= rd_score;
    end
    if (v1_q) begin
      w_q   <= w;
      val_q <= rd_val;
    end
    if (cmd_i.sum_init) begin
      num_q <= '0;
      den_q <= '0;
    end else if (v2_q) begin
      num_q <= num_q + NUM_W'(prod);
      den_q <= den_q + DEN_W'(w_q);
    end
    if (cmd_i.div_start) begin
      quo_q <= mag + NUM_W'(den_q >> 1);
      rem_q <= '0;
      neg_q <= num_q[NUM_W-1];
    end else if (div_act_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_val_q  <= sat_val;
      out_lane_q <= cmd_i.out_lane;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign sts_o.pipe_busy = v1_q | v2_q;
  assign sts_o.div_busy  = div_act_q;

  assign compressed_value_o = out_val_q;
  assign lane_index_o       = out_lane_q;
  assign last_of_window_o   = out_last_q;

endmodule
`default_nettype wire

### rtl/core/rolling_softmax_token_compressor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_softmax_token_compressor: softmax-gated kv pooling
// windowed token store with per-lane softmax-weighted mean on window close
// ----------------------------------------------------------------------------
// After reset the block clears its 16384-entry slot store, one entry a cycle,
// and stalls its input until the clear ends; register writes are taken
// meanwhile. An element that emits nothing is taken without a stall. An element
// of a window's closing token that emits a lane stalls the input for two walks
// of N entries over the slot store, N being ratio (2*ratio in overlap mode)
// (max search, then weighted sums) and a 40-step bit-serial divider. The next
// element is taken while the finished lane still waits at the output register.
module rolling_softmax_token_compressor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] kv_value_i,
  input  logic signed [15:0] score_value_i,
  input  logic signed [15:0] position_bias_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] compressed_value_o,
  output logic [6:0]         lane_index_o,
  output logic               last_of_window_o
);
  import rstc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr_acc;

  assign pready = 1'b1;
  assign wr_acc = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio <= 6'd4;
      cfg_q.head  <= 8'd128;
      cfg_q.ovl   <= 1'b1;
    end else if (wr_acc) begin
      unique case (paddr[3:2])
        REG_WINDOW_RATIO: cfg_q.ratio <= pwdata[5:0];
        REG_HEAD_WIDTH:   cfg_q.head  <= pwdata[7:0];
        REG_OVERLAP_MODE: cfg_q.ovl   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_RATIO: prdata = {26'd0, cfg_q.ratio};
      REG_HEAD_WIDTH:   prdata = {24'd0, cfg_q.head};
      REG_OVERLAP_MODE: prdata = {31'd0, cfg_q.ovl};
      default:          prdata = 32'd0;
    endcase
  end

  rstc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .last_element_i (last_element_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  rstc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kv_value_i         (kv_value_i),
    .score_value_i      (score_value_i),
    .position_bias_i    (position_bias_i),
    .compressed_value_o (compressed_value_o),
    .lane_index_o       (lane_index_o),
    .last_of_window_o   (last_of_window_o)
  );

endmodule
`default_nettype wire

### rtl/core/rstc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rstc_checker: port-level checks
// output hold under stall, register port readiness, result latency
// ----------------------------------------------------------------------------
module rstc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] compressed_value_o,
  input logic [6:0]  lane_index_o,
  input logic        last_of_window_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(compressed_value_o)
      && $stable(lane_index_o) && $stable(last_of_window_o))
    else $error("stalled output beat changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port not ready");

  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result beat appeared one cycle after input beat");

endmodule

bind rolling_softmax_token_compressor rstc_checker u_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .pready             (pready),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .compressed_value_o (compressed_value_o),
  .lane_index_o       (lane_index_o),
  .last_of_window_o   (last_of_window_o)
);
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: rolling softmax token compressor testbench
// drives element beats and register writes, predicts each pooled lane from a
// local model of the slot store, and checks every output beat in order
// ----------------------------------------------------------------------------
module tb_top;
  import rstc_pkg::*;

  localparam int  SLOTS     = 2 * MAX_RATIO;
  localparam int  LANES     = 2 * MAX_HEAD;
  localparam int  LIMIT     = 3000000;
  localparam int  SETTLE    = 250;
  localparam int  TBL       = 1 << EXP_TABLE_BITS;

  typedef struct {
    logic [15:0] value;
    logic [6:0]  lane;
    logic        last;
  } pooled_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] kv_value_i = '0, score_value_i = '0, position_bias_i = '0;
  logic               last_element_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] compressed_value_o;
  logic [6:0]         lane_index_o;
  logic               last_of_window_o;

  rolling_softmax_token_compressor DUT (.*);

  always #4 clk_i = ~clk_i;

  // local copy of block state
  logic signed [15:0] value_mem [SLOTS*LANES];
  logic signed [15:0] score_mem [SLOTS*LANES];
  int                 exp_weight [TBL];
  bit                 bank_sel;
  int                 cursor, elem_cnt;
  logic [5:0]         ratio_reg;
  logic [7:0]         head_reg;
  logic               ovl_reg;

  pooled_t pooled_q[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      items_sent = 0;
  bit      tx_idle = 1'b1, rx_idle = 1'b1;
  bit      hold_req = 1'b0, hold_on = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[rolling_softmax_token_compressor] ERROR");
      $finish;
    end
  end

  function automatic void build_weights();
    longint          sum, term;
    longint unsigned e, p;
    sum  = 64'sd1 << 32;
    term = 64'sd1 << 32;
    for (int n = 1; n <= 40; n++) begin
      term = (term >>> (EXP_TABLE_BITS - 4)) / n;
      if (n & 1) sum -= term;
      else sum += term;
    end
    e = longint'(sum);
    p = 64'd1 << 32;
    for (int k = 0; k < TBL; k++) begin
      exp_weight[k] = int'((p + 64'd32768) >> 16);
      p = (p * e) >> 32;
    end
  endfunction

  function automatic int weight(int sc, int maxs);
    int neg;
    neg = maxs - sc;
    if (neg >= 4096) return 0;
    return exp_weight[neg >> (12 - EXP_TABLE_BITS)];
  endfunction

  function automatic int clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int pool_lane(int lane, int ratio, int h, bit ovl);
    int     cur_base, prev_base, maxs, i, w;
    longint num, den, q;
    cur_base  = (bank_sel ? MAX_RATIO : 0) * LANES;
    prev_base = (bank_sel ? 0 : MAX_RATIO) * LANES;
    maxs = -32768;
    num  = 0;
    den  = 0;
    for (int s = 0; s < ratio; s++) begin
      if (ovl) begin
        if (int'(score_mem[prev_base + s*LANES + lane]) > maxs)
          maxs = score_mem[prev_base + s*LANES + lane];
        if (int'(score_mem[cur_base + s*LANES + lane + h]) > maxs)
          maxs = score_mem[cur_base + s*LANES + lane + h];
      end else if (int'(score_mem[cur_base + s*LANES + lane]) > maxs) begin
        maxs = score_mem[cur_base + s*LANES + lane];
      end
    end
    for (int s = 0; s < ratio; s++) begin
      i = ovl ? prev_base + s*LANES + lane : cur_base + s*LANES + lane;
      w = weight(score_mem[i], maxs);
      den += w;
      num += longint'(w) * value_mem[i];
      if (ovl) begin
        i = cur_base + s*LANES + lane + h;
        w = weight(score_mem[i], maxs);
        den += w;
        num += longint'(w) * value_mem[i];
      end
    end
    if (den <= 0) return 0;
    if (num >= 0) q = (num + den / 2) / den;
    else q = -((-num + den / 2) / den);
    return clip16(q);
  endfunction

  function automatic void absorb_element(logic signed [15:0] v, logic signed [15:0] s,
                                         logic signed [15:0] b, logic last);
    int      ratio, h, tw, cur, i, lane;
    bit      ovl, closing;
    pooled_t r;
    ratio = (ratio_reg == 0) ? 1 : (ratio_reg > MAX_RATIO) ? MAX_RATIO : ratio_reg;
    h     = (head_reg == 0) ? 1 : (head_reg > MAX_HEAD) ? MAX_HEAD : head_reg;
    ovl   = ovl_reg;
    tw    = ovl ? 2 * h : h;
    cur   = (cursor < ratio) ? cursor : ratio - 1;
    closing = (cur == ratio - 1);
    if (elem_cnt < tw) begin
      i = ((bank_sel ? MAX_RATIO : 0) + cur) * LANES + elem_cnt;
      value_mem[i] = v;
      score_mem[i] = 16'(clip16(longint'(s) + longint'(b)));
      if (closing && (!ovl || elem_cnt >= h)) begin
        lane    = ovl ? elem_cnt - h : elem_cnt;
        r.value = 16'(pool_lane(lane, ratio, h, ovl));
        r.lane  = 7'(lane);
        r.last  = (lane == h - 1);
        pooled_q.push_back(r);
      end
      elem_cnt++;
    end
    if (last) begin
      elem_cnt = 0;
      if (closing) begin
        cursor = 0;
        if (ovl) bank_sel = ~bank_sel;
      end else begin
        cursor = cur + 1;
      end
    end
  endfunction

  // result checker and receiver stall
  initial begin
    pooled_t want;
    int      stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pooled_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: value %0d lane %0d last %0b",
                     compressed_value_o, lane_index_o, last_of_window_o);
        end else begin
          want = pooled_q.pop_front();
          if (compressed_value_o !== want.value || lane_index_o !== want.lane ||
              last_of_window_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %0d lane %0d last %0b, got %0d %0d %0b",
                       $signed(want.value), want.lane, want.last,
                       compressed_value_o, lane_index_o, last_of_window_o);
          end
        end
        stall_left = rx_idle ? $urandom_range(0, 10) : 0;
      end
      if (hold_on) out_stall_i <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  // long receiver hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on  = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_on  = 1'b0;
      end
    end
  end

  task automatic send_element(logic signed [15:0] v, logic signed [15:0] s,
                              logic signed [15:0] b, logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kv_value_i      <= v;
    score_value_i   <= s;
    position_bias_i <= b;
    last_element_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_element(v, s, b, last);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pooled_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WINDOW_RATIO: ratio_reg = data[5:0];
      REG_HEAD_WIDTH:   head_reg  = data[7:0];
      REG_OVERLAP_MODE: ovl_reg   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int ratio, int head, bit ovl);
    write_reg(REG_WINDOW_RATIO, ratio);
    write_reg(REG_HEAD_WIDTH, head);
    write_reg(REG_OVERLAP_MODE, ovl);
  endtask

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  // one token of the given length, last beat flagged
  task automatic send_token(int len);
    for (int k = 0; k < len; k++)
      send_element(rand_q88(), rand_q88(), rand_q88(), k == len - 1);
  endtask

  task automatic test_extremes();
    logic [15:0] ext [4];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    set_config(1, 1, 1'b0);
    for (int k = 0; k < 8; k++)
      send_element(ext[k % 4], ext[(k + 1) % 4], ext[(k / 2) % 4], 1'b1);
    drain();
  endtask

  task automatic test_overlong_and_short();
    set_config(2, 2, 1'b1);
    send_token(6);
    send_token(1);
    send_token(4);
    send_token(3);
    drain();
  endtask

  task automatic test_clamped_regs();
    set_config(0, 0, 1'b1);
    send_token(2);
    send_token(2);
    drain();
    set_config(63, 1, 1'b0);
    for (int k = 0; k < 32; k++) send_token(1);
    drain();
  endtask

  task automatic test_widest_head();
    set_config(1, 255, 1'b0);
    send_token(130);
    drain();
  endtask

  task automatic test_backpressure();
    set_config(1, 8, 1'b0);
    tx_idle = 1'b0;
    hold_req = 1'b1;
    send_token(24);
    tx_idle = 1'b1;
    drain();
  endtask

  task automatic test_pause_mid_window();
    set_config(3, 3, 1'b1);
    send_token(6);
    send_token(6);
    send_token(3);
    in_valid_i <= 1'b0;
    while (pooled_q.size() > 0) @(posedge clk_i);
    send_token(3);
    send_token(6);
    drain();
  endtask

  task automatic test_random(int budget);
    int ratio_opts [9];
    int ratio, head, tw, len, phase_end;
    bit ovl;
    ratio_opts = '{0, 1, 2, 3, 4, 5, 8, 32, 63};
    while (items_sent < budget) begin
      ratio = ratio_opts[$urandom_range(0, 8)];
      head  = $urandom_range(0, 6);
      ovl   = $urandom_range(0, 1);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      set_config(ratio, head, ovl);
      tw = (head == 0 ? 1 : head) * (ovl ? 2 : 1);
      phase_end = items_sent + $urandom_range(40, 140);
      while (items_sent < phase_end && items_sent < budget) begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(1, tw);
          1: len = tw + $urandom_range(1, 3);
          default: len = tw;
        endcase
        send_token(len);
      end
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    build_weights();
    for (int i = 0; i < SLOTS*LANES; i++) begin
      value_mem[i] = '0;
      score_mem[i] = '0;
    end
    bank_sel  = 1'b0;
    cursor    = 0;
    elem_cnt  = 0;
    ratio_reg = 6'd4;
    head_reg  = 8'd128;
    ovl_reg   = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_overlong_and_short();
    test_clamped_regs();
    test_widest_head();
    test_backpressure();
    test_pause_mid_window();
    test_random(1250);

    drain();
    if (pooled_q.size() > 0) mismatches++;
    if (mismatches == 0) $display("[rolling_softmax_token_compressor] OK");
    else $display("[rolling_softmax_token_compressor] ERROR");
    $finish;
  end

endmodule
